// ===== rtl/range_minimum_segment_tree_assert.svh =====
// assertion macros for the range minimum segment tree
// used by the top level only, no other dependencies
`ifndef RANGE_MINIMUM_SEGMENT_TREE_ASSERT_SVH
`define RANGE_MINIMUM_SEGMENT_TREE_ASSERT_SVH
// implication checked on every edge outside reset
`define RMST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define RMST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/rmst_pkg.sv =====
// package for the range minimum segment tree: constants, state codes
// no dependencies
`default_nettype none
package rmst_pkg;
  localparam int ENTRIES_DEF = 1024;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] LARGEST_BIASED = 32'hFFFF_FFFF;
  localparam logic [31:0] BIAS = 32'h8000_0000;
  localparam logic [10:0] SIZE_RESET = 11'd1024;
  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WLEAF, ST_WRD, ST_WWAIT, ST_WMIN,
    ST_QSTEP, ST_QWAIT0, ST_QWAIT1, ST_QNEXT, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/rmst_mem.sv =====
// simple dual-port tree memory, one write and one registered read per cycle
// uses no package
`default_nettype none
module rmst_mem #(
  parameter int DEPTH = 2048,
  parameter int AW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);
  logic [31:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/range_minimum_segment_tree.sv =====
// range minimum segment tree: top level, sequencer around one tree memory
// depends on rmst_pkg, rmst_mem and range_minimum_segment_tree_assert.svh
//
// usage:
//  in_ channel takes a beat: kind 1 writes new_value at first_index, kind 0
//  queries the minimum over first_index..last_index inclusive
//  out_ channel returns one beat per query: minimum and nothing_in_range
//  writes give no beat; positions at or beyond size_in_use are ignored
//  cfg_ channel writes size_in_use (saturated to ENTRIES); the user must write
//  it only when idle, unchecked by the block; one item at a time, set by the
//  single memory read port; write: leaf write, then read two children per level
//  and write their min; query: a step per level; empty spans go to the output
//  after reset a clearing pass writes the largest value into all 2*ENTRIES
//  nodes, one a cycle, in_ready low
//  the result waits in an output register while out_ready is low; the
//  next item is taken only once that beat is delivered
`default_nettype none
`include "range_minimum_segment_tree_assert.svh"
module range_minimum_segment_tree
  import rmst_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [9:0]  in_first_index,
  input  wire logic [9:0]  in_last_index,
  input  wire logic signed [31:0] in_new_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_minimum,
  output logic             out_nothing_in_range,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_size_in_use
);
  localparam int LW = $clog2(ENTRIES);   // index bits
  localparam int AW = LW + 1;            // node address bits
  localparam int DEPTH = 2 * ENTRIES;

  state_t state_r, state_nxt;
  logic [10:0] size_r;
  logic [AW:0] lo_r, lo_nxt, hi_r, hi_nxt;   // one extra bit for hi = 2*ENTRIES
  logic [AW-1:0] node_r, node_nxt, clr_r, clr_nxt;
  logic [31:0] best_r, best_nxt, left_r, left_nxt;
  logic        empty_r, empty_nxt;
  logic [31:0] wval_r, wval_nxt;
  logic        rd_hi_r, rd_hi_nxt;   // pending second read in query level

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  rmst_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // effective size, saturated to ENTRIES
  logic [16:0] sz_eff;
  always_comb begin
    if ({6'd0, size_r} > 17'(ENTRIES)) sz_eff = 17'(ENTRIES);
    else sz_eff = {6'd0, size_r};
  end

  logic [16:0] first_x, last_x;
  assign first_x = 17'(in_first_index);
  assign last_x  = 17'(in_last_index);

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= SIZE_RESET;
    else if (cfg_valid) size_r <= cfg_size_in_use;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_WRITE) begin
            state_nxt = (first_x < sz_eff) ? ST_WLEAF : ST_IDLE;
          end else if (sz_eff == 17'd0 || first_x >= sz_eff || first_x > last_x) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_QSTEP;
          end
        end
      end
      ST_WLEAF: state_nxt = ST_WRD;
      ST_WRD:   state_nxt = ST_WWAIT;
      ST_WWAIT: state_nxt = ST_WMIN;
      ST_WMIN:  state_nxt = (node_r == AW'(1)) ? ST_IDLE : ST_WRD;
      ST_QSTEP: begin
        if (lo_r >= hi_r) state_nxt = ST_OUT;
        else if (lo_r[0] || hi_r[0]) state_nxt = ST_QWAIT0;
        else state_nxt = ST_QSTEP;
      end
      ST_QWAIT0: state_nxt = rd_hi_r ? ST_QWAIT1 : ST_QNEXT;
      ST_QWAIT1: state_nxt = ST_QNEXT;
      ST_QNEXT:  state_nxt = ST_QSTEP;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    lo_nxt = lo_r; hi_nxt = hi_r; node_nxt = node_r; clr_nxt = clr_r;
    best_nxt = best_r; left_nxt = left_r; empty_nxt = empty_r;
    wval_nxt = wval_r; rd_hi_nxt = rd_hi_r;
    we = 1'b0; waddr = node_r; wdata = wval_r; raddr = node_r;
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_r; wdata = LARGEST_BIASED;
        clr_nxt = clr_r + AW'(1);
      end
      ST_IDLE: begin
        node_nxt = AW'(ENTRIES) + AW'(in_first_index);
        wval_nxt = in_new_value ^ BIAS;
        best_nxt = LARGEST_BIASED;
        empty_nxt = 1'b1;
        lo_nxt = (AW+1)'(ENTRIES) + (AW+1)'(in_first_index);
        if (last_x >= sz_eff)
          hi_nxt = (AW+1)'(ENTRIES) + (AW+1)'(sz_eff);
        else
          hi_nxt = (AW+1)'(ENTRIES) + (AW+1)'(in_last_index) + (AW+1)'(1);
        if (in_valid && in_kind == KIND_QUERY && !(sz_eff == 17'd0 ||
            first_x >= sz_eff || first_x > last_x))
          empty_nxt = 1'b0;
      end
      ST_WLEAF: begin
        we = 1'b1; waddr = node_r; wdata = wval_r;
        node_nxt = node_r >> 1;
      end
      ST_WRD: raddr = {node_r[AW-2:0], 1'b0};
      ST_WWAIT: begin
        raddr = {node_r[AW-2:0], 1'b1};
        left_nxt = rdata;
      end
      ST_WMIN: begin
        we = 1'b1; waddr = node_r;
        wdata = (left_r < rdata) ? left_r : rdata;
        node_nxt = node_r >> 1;
      end
      ST_QSTEP: begin
        rd_hi_nxt = 1'b0;
        if (lo_r < hi_r) begin
          if (lo_r[0]) begin
            raddr = lo_r[AW-1:0];
            lo_nxt = lo_r + (AW+1)'(1);
            if (hi_r[0]) begin
              rd_hi_nxt = 1'b1;
              hi_nxt = hi_r - (AW+1)'(1);
            end
          end else if (hi_r[0]) begin
            raddr = AW'(hi_r - (AW+1)'(1));
            hi_nxt = hi_r - (AW+1)'(1);
          end else begin
            lo_nxt = lo_r >> 1;
            hi_nxt = hi_r >> 1;
          end
        end
      end
      ST_QWAIT0: begin
        raddr = hi_r[AW-1:0];
        best_nxt = (rdata < best_r) ? rdata : best_r;
      end
      ST_QWAIT1: best_nxt = (rdata < best_r) ? rdata : best_r;
      ST_QNEXT: begin
        lo_nxt = lo_r >> 1;
        hi_nxt = hi_r >> 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      rd_hi_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      rd_hi_r <= rd_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; node_r <= node_nxt;
    best_r <= best_nxt; left_r <= left_nxt; empty_r <= empty_nxt;
    wval_r <= wval_nxt;
  end

  // outputs
  always_comb begin
    out_valid = (state_r == ST_OUT);
    out_minimum = best_r ^ BIAS;
    out_nothing_in_range = empty_r;
  end

  `RMST_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !out_valid)
  `RMST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_minimum))
  `RMST_ASSERT_IMP(a_empty_max, clk, rst_n, out_valid && out_nothing_in_range, out_minimum == INT_MAX)
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for range_minimum_segment_tree: point writes and range minimum queries
// checked against a plain array predictor; depends on rmst_pkg and the rtl top level
`timescale 1ns / 1ps
module tb
  import rmst_pkg::*;
();

  localparam int POSITIONS = 1024;
  localparam int CYCLE_LIMIT = 1_500_000;
  // settle time before a size change: a write gives no beat but may still be running
  localparam int WRITE_SETTLE = 60;

  typedef struct packed {
    logic signed [31:0] minimum;
    logic               nothing_in_range;
  } range_min_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_kind;
  logic [9:0] in_first_index;
  logic [9:0] in_last_index;
  logic signed [31:0] in_new_value;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_minimum;
  logic out_nothing_in_range;
  logic cfg_valid;
  logic cfg_ready;
  logic [10:0] cfg_size_in_use;

  // predictor state: one signed value per position, plus the size register
  logic signed [31:0] position_values[POSITIONS];
  int unsigned size_now;
  range_min_t pending_minimums[$];

  int fail_count;
  int unsigned cycle_count;
  int unsigned hold_off_cycles;  // long receiver stall requested by a test
  bit steady_flow;               // no idling on either side while set

  range_minimum_segment_tree u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_first_index(in_first_index),
    .in_last_index(in_last_index),
    .in_new_value(in_new_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_minimum(out_minimum),
    .out_nothing_in_range(out_nothing_in_range),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_size_in_use(cfg_size_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  // expected result of a query: clip the span to the size in use, then scan
  function automatic range_min_t predict_range_min(input int unsigned first,
                                                   input int unsigned last);
    range_min_t res;
    int unsigned span_end;
    res.minimum = INT_MAX;
    res.nothing_in_range = 1'b1;
    if (size_now == 0 || first >= size_now || first > last) return res;
    span_end = (last >= size_now) ? size_now - 1 : last;
    res.nothing_in_range = 1'b0;
    for (int unsigned p = first; p <= span_end; p++)
      if (position_values[p] < res.minimum) res.minimum = position_values[p];
    return res;
  endfunction

  // one input beat; valid stays up afterwards so back-to-back beats need no toggle
  task automatic send_item(input logic kind, input logic [9:0] first,
                           input logic [9:0] last, input logic signed [31:0] value);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_first_index <= first;
    in_last_index <= last;
    in_new_value <= value;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (kind == KIND_WRITE) begin
      if (first < size_now) position_values[first] = value;
    end else begin
      pending_minimums.insert(pending_minimums.size(), predict_range_min(first, last));
    end
  endtask

  task automatic send_gap();
    int unsigned n;
    n = idle_length();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_and_gap(input logic kind, input logic [9:0] first,
                              input logic [9:0] last, input logic signed [31:0] value);
    send_item(kind, first, last, value);
    send_gap();
  endtask

  // wait for all beats, let a trailing write finish, then load a new size
  task automatic write_size(input logic [10:0] size_value);
    in_valid <= 1'b0;
    while (pending_minimums.size() != 0) @(posedge clk);
    repeat (WRITE_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_size_in_use <= size_value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    size_now = (size_value > POSITIONS) ? POSITIONS : size_value;
  endtask

  // corners of the fields and each special case of spans and sizes
  task automatic test_directed();
    write_size(11'd1024);
    send_and_gap(KIND_QUERY, 10'd0, 10'd1023, 0);         // untouched tree
    send_and_gap(KIND_QUERY, 10'd5, 10'd4, 0);            // empty span
    send_and_gap(KIND_WRITE, 10'd0, 10'd0, 32'sh7FFF_FFFF);
    send_and_gap(KIND_WRITE, 10'd1023, 10'd1023, 32'sh8000_0000);
    send_and_gap(KIND_WRITE, 10'd512, 10'h3FF, -1);
    send_and_gap(KIND_WRITE, 10'd511, 10'd0, 0);
    send_and_gap(KIND_QUERY, 10'd0, 10'd1023, 0);
    send_and_gap(KIND_QUERY, 10'd0, 10'd511, 0);
    send_and_gap(KIND_QUERY, 10'd512, 10'd512, 0);
    send_and_gap(KIND_QUERY, 10'd1023, 10'd1023, 0);
    send_and_gap(KIND_QUERY, 10'd1023, 10'd0, 0);
    write_size(11'd5);
    send_and_gap(KIND_WRITE, 10'd7, 10'd0, -100);        // outside size, dropped
    send_and_gap(KIND_WRITE, 10'd4, 10'd0, -7);
    send_and_gap(KIND_QUERY, 10'd2, 10'd1023, 0);         // clipped end
    send_and_gap(KIND_QUERY, 10'd6, 10'd9, 0);            // starts beyond size
    send_and_gap(KIND_QUERY, 10'd5, 10'd5, 0);
    write_size(11'd0);
    send_and_gap(KIND_WRITE, 10'd0, 10'd0, -5);          // every write dropped
    send_and_gap(KIND_QUERY, 10'd0, 10'd1023, 0);
    write_size(11'd2047);                                 // saturates, old values return
    send_and_gap(KIND_QUERY, 10'd0, 10'd1023, 0);
    send_and_gap(KIND_QUERY, 10'd600, 10'd1023, 0);
    send_and_gap(KIND_QUERY, 10'd5, 10'd1022, 0);
  endtask

  // random phases over several sizes: mostly writes and in-size spans, some noise
  task automatic test_random();
    logic [10:0] phase_sizes[6];
    int unsigned sz;
    int unsigned r;
    logic [9:0] first;
    logic [9:0] last;
    logic signed [31:0] value;
    phase_sizes = '{11'd1, 11'd1024, 11'd37, 11'd2047, 11'd3, 11'd0};
    phase_sizes[5] = 11'($urandom_range(1, 2047));
    foreach (phase_sizes[ph]) begin
      write_size(phase_sizes[ph]);
      steady_flow = (ph == 2);
      sz = (size_now == 0) ? 1 : size_now;
      for (int i = 0; i < 240; i++) begin
        r = $urandom_range(0, 99);
        first = 10'($urandom_range(0, sz - 1));
        last = 10'($urandom_range(first, (sz - 1 > first) ? sz - 1 : first));
        case ($urandom_range(0, 3))
          0: value = $urandom;
          1: value = $signed(32'($urandom_range(0, 200))) - 100;
          2: value = ($urandom_range(0, 1) != 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          default: value = $signed(32'($urandom_range(0, 1_000_000)));
        endcase
        if (r < 40) begin
          send_and_gap(KIND_WRITE, first, 10'($urandom), value);
        end else if (r < 85) begin
          send_and_gap(KIND_QUERY, first, last, $urandom);
        end else begin
          // noise: any bit pattern, many of them empty or beyond size
          send_and_gap(1'($urandom), 10'($urandom), 10'($urandom), $urandom);
        end
      end
      steady_flow = 1'b0;
    end
  endtask

  // receiver stalls for a long stretch while queries keep arriving
  task automatic test_backpressure();
    write_size(11'd1024);
    // arm the hold mid-cycle so the receiver process cannot overwrite it
    @(negedge clk);
    hold_off_cycles = 400;
    @(posedge clk);
    for (int i = 0; i < 12; i++)
      send_item(KIND_QUERY, 10'($urandom_range(0, 500)), 10'($urandom_range(500, 1023)), 0);
    in_valid <= 1'b0;
  endtask

  // receiver side: random stalls, or a long counted hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (steady_flow) begin
      out_ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: out_ready <= 1'b1;
        [70:96]: out_ready <= 1'b0;
        default: begin
          out_ready <= 1'b0;
          hold_off_cycles <= $urandom_range(10, 40);
        end
      endcase
    end
  end

  // result beats are sampled mid-cycle, where every signal is settled
  always @(negedge clk) begin
    range_min_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_minimums.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = pending_minimums.pop_front();
        if (out_minimum !== want.minimum)
          report($sformatf("minimum %0d, expected %0d", out_minimum, want.minimum));
        if (out_nothing_in_range !== want.nothing_in_range)
          report($sformatf("nothing_in_range %0b, expected %0b",
                           out_nothing_in_range, want.nothing_in_range));
      end
    end
  end

  // guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    steady_flow = 1'b0;
    size_now = SIZE_RESET;
    foreach (position_values[p]) position_values[p] = INT_MAX;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_QUERY;
    in_first_index = '0;
    in_last_index = '0;
    in_new_value = '0;
    cfg_valid = 1'b0;
    cfg_size_in_use = SIZE_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();
    test_backpressure();

    while (pending_minimums.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_minimums.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rmst_pkg.sv
rtl/rmst_mem.sv
rtl/range_minimum_segment_tree.sv
tb/tb.sv
